// ===== rtl/core/wja_pkg.sv =====
`default_nettype none

package wja_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] prod_t;
  typedef logic        [63:0] mag_t;
  typedef logic        [1:0]  dim_t;
  typedef logic        [1:0]  cfg_idx_t;

  localparam int unsigned N_ENT = 9;

  localparam cfg_idx_t REG_DIMENSION_MODE = 2'd0;
  localparam cfg_idx_t REG_COEFFICIENT    = 2'd1;

  localparam dim_t  DIM_2D         = 2'd2;
  localparam dim_t  DIM_RESET      = 2'd3;
  localparam word_t COEF_RESET     = 32'sd65536;
  localparam word_t WORD_MAX       = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN       = 32'sh8000_0000;

endpackage

`default_nettype wire

// ===== rtl/core/weighted_jacobian_adjugate.sv =====
// Weighted Jacobian adjugate, one quadrature point per beat.
// Input channel (in_valid/in_ready): the nine Jacobian entries and the point
// weight, signed fixed point with FRAC_BITS fraction bits. Result channel
// (out_valid/out_ready): weight * coefficient * adj(J), rounded to nearest
// with ties away from zero and saturated to 32 bits; out_saturated marks a
// clipped entry. In 2D mode only the upper-left 2x2 block is used and the
// third row and column of the result are zero.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 dimension_mode,
// index 1 coefficient; other indexes are dropped. Write only while idle.
// Throughput is one beat per cycle while out_ready is held high, through the
// five-stage multiplier pipeline (products, cross
// difference, partial products, partial sum, round and saturate).
// Each stage has its own valid bit and loads when empty or when the next
// stage loads, so a stalled receiver fills bubbles before in_ready drops.
// A synchronous reset (rst_n low) empties every stage and restores
// dimension_mode = 3 and coefficient = 1.0.
`default_nettype none

module weighted_jacobian_adjugate #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire wja_pkg::cfg_idx_t   cfg_index,
  input  wire logic        [31:0]  cfg_data,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire wja_pkg::word_t      in_jac_r1c1,
  input  wire wja_pkg::word_t      in_jac_r1c2,
  input  wire wja_pkg::word_t      in_jac_r1c3,
  input  wire wja_pkg::word_t      in_jac_r2c1,
  input  wire wja_pkg::word_t      in_jac_r2c2,
  input  wire wja_pkg::word_t      in_jac_r2c3,
  input  wire wja_pkg::word_t      in_jac_r3c1,
  input  wire wja_pkg::word_t      in_jac_r3c2,
  input  wire wja_pkg::word_t      in_jac_r3c3,
  input  wire wja_pkg::word_t      in_point_weight,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      wja_pkg::word_t      out_r1c1,
  output      wja_pkg::word_t      out_r1c2,
  output      wja_pkg::word_t      out_r1c3,
  output      wja_pkg::word_t      out_r2c1,
  output      wja_pkg::word_t      out_r2c2,
  output      wja_pkg::word_t      out_r2c3,
  output      wja_pkg::word_t      out_r3c1,
  output      wja_pkg::word_t      out_r3c2,
  output      wja_pkg::word_t      out_r3c3,
  output      logic                out_saturated
);

  localparam int Sh = 3 * FRAC_BITS;
  localparam int Qw = 128 - Sh;
  localparam logic [127:0] RoundBit = 128'(1) << (Sh - 1);
  localparam wja_pkg::word_t OneQ = 32'(64'd1 << FRAC_BITS);

  // configuration registers
  wja_pkg::dim_t  dim_mode_r;
  wja_pkg::word_t coef_r;

  // stage valid bits and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy2, rdy3, rdy4, rdy5;

  // stage 1: products
  wja_pkg::word_t jv  [wja_pkg::N_ENT];
  wja_pkg::word_t opa [wja_pkg::N_ENT];
  wja_pkg::word_t opb [wja_pkg::N_ENT];
  wja_pkg::word_t opc [wja_pkg::N_ENT];
  wja_pkg::word_t opd [wja_pkg::N_ENT];
  wja_pkg::prod_t p1_r [wja_pkg::N_ENT];
  wja_pkg::prod_t p2_r [wja_pkg::N_ENT];
  wja_pkg::prod_t cw_r;

  // stage 2: sign and magnitude
  logic signed [64:0] diff [wja_pkg::N_ENT];
  wja_pkg::mag_t      am_nxt [wja_pkg::N_ENT];
  logic               neg_nxt [wja_pkg::N_ENT];
  wja_pkg::prod_t     cw_neg_val;
  wja_pkg::mag_t      am_r [wja_pkg::N_ENT];
  logic               neg2_r [wja_pkg::N_ENT];
  logic [62:0]        cwm_r;

  // stage 3: partial products
  logic [63:0] ll_r [wja_pkg::N_ENT];
  logic [63:0] lh_r [wja_pkg::N_ENT];
  logic [63:0] hl_r [wja_pkg::N_ENT];
  logic [63:0] hh_r [wja_pkg::N_ENT];
  logic        neg3_r [wja_pkg::N_ENT];

  // stage 4: middle sum
  logic [63:0] ll4_r [wja_pkg::N_ENT];
  logic [63:0] hh4_r [wja_pkg::N_ENT];
  logic [64:0] mid_r [wja_pkg::N_ENT];
  logic        neg4_r [wja_pkg::N_ENT];

  // stage 5: round, saturate, sign
  logic [127:0]   full [wja_pkg::N_ENT];
  logic [Qw-1:0]  q    [wja_pkg::N_ENT];
  logic [31:0]    lim  [wja_pkg::N_ENT];
  logic [31:0]    mag  [wja_pkg::N_ENT];
  logic           sat  [wja_pkg::N_ENT];
  logic [31:0]    res_nxt [wja_pkg::N_ENT];
  logic           sat_nxt;
  wja_pkg::word_t res_r [wja_pkg::N_ENT];
  logic           sat_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_mode_r <= wja_pkg::DIM_RESET;
      coef_r     <= wja_pkg::COEF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wja_pkg::REG_DIMENSION_MODE: dim_mode_r <= cfg_data[1:0];
        wja_pkg::REG_COEFFICIENT:    coef_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = !v1_r || rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (rdy2)     v2_r <= v1_r;
      if (rdy3)     v3_r <= v2_r;
      if (rdy4)     v4_r <= v3_r;
      if (rdy5)     v5_r <= v4_r;
    end
  end

  // operand select: 2D entries become x * 1.0 so every path scales by 3*FRAC_BITS
  always_comb begin
    jv[0] = in_jac_r1c1;
    jv[1] = in_jac_r1c2;
    jv[2] = in_jac_r1c3;
    jv[3] = in_jac_r2c1;
    jv[4] = in_jac_r2c2;
    jv[5] = in_jac_r2c3;
    jv[6] = in_jac_r3c1;
    jv[7] = in_jac_r3c2;
    jv[8] = in_jac_r3c3;
    for (int k = 0; k < wja_pkg::N_ENT; k++) begin
      opa[k] = '0;
      opb[k] = '0;
      opc[k] = '0;
      opd[k] = '0;
    end
    if (dim_mode_r == wja_pkg::DIM_2D) begin
      opa[0] = jv[4]; opb[0] = OneQ;
      opc[1] = jv[1]; opd[1] = OneQ;
      opc[3] = jv[3]; opd[3] = OneQ;
      opa[4] = jv[0]; opb[4] = OneQ;
    end else begin
      opa[0] = jv[4]; opb[0] = jv[8]; opc[0] = jv[5]; opd[0] = jv[7];
      opa[1] = jv[7]; opb[1] = jv[2]; opc[1] = jv[1]; opd[1] = jv[8];
      opa[2] = jv[1]; opb[2] = jv[5]; opc[2] = jv[4]; opd[2] = jv[2];
      opa[3] = jv[6]; opb[3] = jv[5]; opc[3] = jv[3]; opd[3] = jv[8];
      opa[4] = jv[0]; opb[4] = jv[8]; opc[4] = jv[2]; opd[4] = jv[6];
      opa[5] = jv[3]; opb[5] = jv[2]; opc[5] = jv[0]; opd[5] = jv[5];
      opa[6] = jv[3]; opb[6] = jv[7]; opc[6] = jv[6]; opd[6] = jv[4];
      opa[7] = jv[6]; opb[7] = jv[1]; opc[7] = jv[0]; opd[7] = jv[7];
      opa[8] = jv[0]; opb[8] = jv[4]; opc[8] = jv[1]; opd[8] = jv[3];
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      for (int k = 0; k < wja_pkg::N_ENT; k++) begin
        p1_r[k] <= opa[k] * opb[k];
        p2_r[k] <= opc[k] * opd[k];
      end
      cw_r <= in_point_weight * coef_r;
    end
  end

  always_comb begin
    for (int k = 0; k < wja_pkg::N_ENT; k++) begin
      diff[k]    = {p1_r[k][63], p1_r[k]} - {p2_r[k][63], p2_r[k]};
      neg_nxt[k] = diff[k][64];
      am_nxt[k]  = neg_nxt[k] ? 64'(-diff[k]) : diff[k][63:0];
    end
    cw_neg_val = -cw_r;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int k = 0; k < wja_pkg::N_ENT; k++) begin
        am_r[k]   <= am_nxt[k];
        neg2_r[k] <= neg_nxt[k] ^ cw_r[63];
      end
      cwm_r <= cw_r[63] ? cw_neg_val[62:0] : cw_r[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int k = 0; k < wja_pkg::N_ENT; k++) begin
        ll_r[k]   <= 64'(cwm_r[31:0])  * 64'(am_r[k][31:0]);
        lh_r[k]   <= 64'(cwm_r[31:0])  * 64'(am_r[k][63:32]);
        hl_r[k]   <= 64'(cwm_r[62:32]) * 64'(am_r[k][31:0]);
        hh_r[k]   <= 64'(cwm_r[62:32]) * 64'(am_r[k][63:32]);
        neg3_r[k] <= neg2_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int k = 0; k < wja_pkg::N_ENT; k++) begin
        ll4_r[k]  <= ll_r[k];
        hh4_r[k]  <= hh_r[k];
        mid_r[k]  <= {1'b0, lh_r[k]} + {1'b0, hl_r[k]};
        neg4_r[k] <= neg3_r[k];
      end
    end
  end

  always_comb begin
    sat_nxt = 1'b0;
    for (int k = 0; k < wja_pkg::N_ENT; k++) begin
      full[k] = {hh4_r[k], ll4_r[k]} + {31'b0, mid_r[k], 32'b0} + RoundBit;
      q[k]    = full[k][127:Sh];
      lim[k]  = neg4_r[k] ? wja_pkg::WORD_MIN : wja_pkg::WORD_MAX;
      sat[k]  = (|q[k][Qw-1:32]) || (q[k][31:0] > lim[k]);
      mag[k]  = sat[k] ? lim[k] : q[k][31:0];
      res_nxt[k] = neg4_r[k] ? -mag[k] : mag[k];
      sat_nxt = sat_nxt | sat[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      for (int k = 0; k < wja_pkg::N_ENT; k++) begin
        res_r[k] <= res_nxt[k];
      end
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = v5_r;
  assign out_r1c1      = res_r[0];
  assign out_r1c2      = res_r[1];
  assign out_r1c3      = res_r[2];
  assign out_r2c1      = res_r[3];
  assign out_r2c2      = res_r[4];
  assign out_r2c3      = res_r[5];
  assign out_r3c1      = res_r[6];
  assign out_r3c2      = res_r[7];
  assign out_r3c3      = res_r[8];
  assign out_saturated = sat_r;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && v3_r && v4_r && v5_r && !out_ready)
    else $error("input blocked while a stage is empty");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_r1c1 == wja_pkg::WORD_MAX || out_r1c1 == wja_pkg::WORD_MIN ||
      out_r1c2 == wja_pkg::WORD_MAX || out_r1c2 == wja_pkg::WORD_MIN ||
      out_r1c3 == wja_pkg::WORD_MAX || out_r1c3 == wja_pkg::WORD_MIN ||
      out_r2c1 == wja_pkg::WORD_MAX || out_r2c1 == wja_pkg::WORD_MIN ||
      out_r2c2 == wja_pkg::WORD_MAX || out_r2c2 == wja_pkg::WORD_MIN ||
      out_r2c3 == wja_pkg::WORD_MAX || out_r2c3 == wja_pkg::WORD_MIN ||
      out_r3c1 == wja_pkg::WORD_MAX || out_r3c1 == wja_pkg::WORD_MIN ||
      out_r3c2 == wja_pkg::WORD_MAX || out_r3c2 == wja_pkg::WORD_MIN ||
      out_r3c3 == wja_pkg::WORD_MAX || out_r3c3 == wja_pkg::WORD_MIN)
    else $error("saturation flagged but no entry at a limit");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r && !v4_r && !out_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  localparam wja_pkg::dim_t DIM_3D = 2'd3;
  localparam wja_pkg::dim_t DIM_ALT0 = 2'd0;
  localparam wja_pkg::dim_t DIM_ALT1 = 2'd1;
  localparam wja_pkg::cfg_idx_t REG_SPARE_2 = 2'd2;
  localparam wja_pkg::cfg_idx_t REG_SPARE_3 = 2'd3;

  localparam wja_pkg::word_t ONE = 32'sd65536;
  localparam wja_pkg::word_t MX = wja_pkg::WORD_MAX;
  localparam wja_pkg::word_t MN = wja_pkg::WORD_MIN;

  typedef struct packed {
    wja_pkg::word_t [0:8] jac;
    wja_pkg::word_t       weight;
  } point_t;

  typedef struct packed {
    wja_pkg::word_t [0:8] ent;
    logic                 sat;
  } adj_t;

  typedef struct packed {
    wja_pkg::dim_t  dim;
    wja_pkg::word_t coef;
    point_t         pt;
    logic           pin;
    adj_t           want;
  } row_t;

  localparam wja_pkg::word_t [0:8] EYE = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
  localparam wja_pkg::word_t [0:8] EYE_2D = '{ONE, 0, 0, 0, ONE, 0, 0, 0, 0};
  localparam wja_pkg::word_t [0:8] EYE_JUNK = '{ONE, 0, MX, 0, ONE, MN, MX, MN, MX};
  localparam wja_pkg::word_t [0:8] ALL_MX = '{MX, MX, MX, MX, MX, MX, MX, MX, MX};
  localparam wja_pkg::word_t [0:8] ALL_MN = '{MN, MN, MN, MN, MN, MN, MN, MN, MN};
  localparam wja_pkg::word_t [0:8] DIAG_MX = '{MX, 0, 0, 0, MX, 0, 0, 0, MX};
  localparam wja_pkg::word_t [0:8] DIAG_MN = '{MN, 0, 0, 0, MN, 0, 0, 0, MN};
  localparam wja_pkg::word_t [0:8] JAC_A = '{
    32'sh0002_0000, 32'sh0001_0000, 32'sh0000_8000,
    32'sh0001_0000, 32'sh0003_0000, 32'shFFFF_0000,
    32'sh0000_4000, 32'sh0001_0000, 32'sh0004_0000};
  localparam wja_pkg::word_t [0:8] JAC_B = '{
    32'shFFFD_8000, 32'sh0000_2000, 32'sh0012_3456,
    32'shFF80_0000, 32'sh7FFF_FFFF, 32'sh0000_0001,
    32'shFFFF_FFFF, 32'sh8000_0000, 32'sh0005_0000};
  localparam wja_pkg::word_t [0:8] JAC_TIE = '{
    32'shFF00_0000, 0, 0, 0, 32'sh0100_0000, 0,
    0, 0, 32'sh0080_0000};
  localparam wja_pkg::word_t [0:8] JAC_TIE_2D = '{
    MN, MN, 0, 32'sh4000_0000, 32'sh8000_0001, 0,
    0, 0, 0};

  localparam int N_ROWS = 20;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{DIM_3D, ONE, '{EYE, ONE}, 1'b1, '{EYE, 1'b0}},
    '{DIM_3D, ONE, '{JAC_A, 32'sd0}, 1'b1, '0},
    '{DIM_3D, ONE, '{ALL_MX, MX}, 1'b1, '0},
    '{DIM_3D, ONE, '{ALL_MN, MN}, 1'b1, '0},
    '{DIM_3D, MX, '{DIAG_MX, MX}, 1'b1, '{DIAG_MX, 1'b1}},
    '{DIM_3D, MN, '{DIAG_MX, MX}, 1'b1, '{DIAG_MN, 1'b1}},
    '{DIM_3D, MN, '{DIAG_MN, MN}, 1'b1, '{DIAG_MX, 1'b1}},
    '{DIM_3D, ONE, '{JAC_A, ONE}, 1'b0, '0},
    '{DIM_3D, ONE, '{JAC_B, -ONE}, 1'b0, '0},
    '{DIM_3D, 32'sd1, '{JAC_TIE, 32'sd1}, 1'b0, '0},
    '{wja_pkg::DIM_2D, ONE, '{EYE_JUNK, ONE}, 1'b1, '{EYE_2D, 1'b0}},
    '{wja_pkg::DIM_2D, MX, '{ALL_MX, MX}, 1'b1,
      '{'{MX, MN, 0, MN, MX, 0, 0, 0, 0}, 1'b1}},
    '{wja_pkg::DIM_2D, MN, '{ALL_MN, MN}, 1'b1,
      '{'{MN, MX, 0, MX, MN, 0, 0, 0, 0}, 1'b1}},
    '{wja_pkg::DIM_2D, 32'sd1, '{JAC_TIE_2D, 32'sd1}, 1'b0, '0},
    '{wja_pkg::DIM_2D, ONE, '{JAC_B, ONE}, 1'b0, '0},
    '{wja_pkg::DIM_2D, 32'sd0, '{JAC_A, MX}, 1'b1, '0},
    '{DIM_ALT0, ONE, '{JAC_A, ONE}, 1'b0, '0},
    '{DIM_ALT1, -ONE, '{JAC_B, ONE}, 1'b0, '0},
    '{DIM_3D, MX, '{JAC_B, MN}, 1'b0, '0},
    '{DIM_3D, ONE, '{JAC_A, MX}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  wja_pkg::cfg_idx_t cfg_index = wja_pkg::REG_DIMENSION_MODE;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  point_t beat = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wja_pkg::word_t out_r1c1, out_r1c2, out_r1c3, out_r2c1, out_r2c2, out_r2c3;
  wja_pkg::word_t out_r3c1, out_r3c2, out_r3c3;
  logic out_saturated;

  logic pin_on = 1'b0;
  adj_t pin_want = '0;

  wja_pkg::dim_t mode_shadow = wja_pkg::DIM_RESET;
  wja_pkg::word_t coef_shadow = wja_pkg::COEF_RESET;
  adj_t pending_adj[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int idle_in = 0;
  int idle_out = 0;

  weighted_jacobian_adjugate #(.FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_jac_r1c1(beat.jac[0]),
    .in_jac_r1c2(beat.jac[1]),
    .in_jac_r1c3(beat.jac[2]),
    .in_jac_r2c1(beat.jac[3]),
    .in_jac_r2c2(beat.jac[4]),
    .in_jac_r2c3(beat.jac[5]),
    .in_jac_r3c1(beat.jac[6]),
    .in_jac_r3c2(beat.jac[7]),
    .in_jac_r3c3(beat.jac[8]),
    .in_point_weight(beat.weight),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_r1c1(out_r1c1),
    .out_r1c2(out_r1c2),
    .out_r1c3(out_r1c3),
    .out_r2c1(out_r2c1),
    .out_r2c2(out_r2c2),
    .out_r2c3(out_r2c3),
    .out_r3c1(out_r3c1),
    .out_r3c2(out_r3c2),
    .out_r3c3(out_r3c3),
    .out_saturated(out_saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // {clipped, value}: divide by 2^shift, round half away from zero, clip to 32 bits
  function automatic logic [32:0] round_clip(input logic signed [131:0] v, input int shift);
    logic [131:0] mag;
    logic [131:0] lim;
    logic clipped;
    mag = v[131] ? -v : v;
    mag = (mag + (132'd1 << (shift - 1))) >> shift;
    lim = v[131] ? 132'h8000_0000 : 132'h7FFF_FFFF;
    clipped = mag > lim;
    if (clipped) begin
      mag = lim;
    end
    return {clipped, v[131] ? -mag[31:0] : mag[31:0]};
  endfunction

  function automatic logic signed [65:0] cofactor(wja_pkg::word_t a, wja_pkg::word_t b,
                                                  wja_pkg::word_t c, wja_pkg::word_t d);
    logic signed [65:0] r;
    r = a * b - c * d;
    return r;
  endfunction

  function automatic adj_t weigh_adjugate(point_t p);
    wja_pkg::word_t j[9];
    wja_pkg::word_t w;
    logic signed [63:0] cw;
    logic signed [65:0] cof[9];
    logic signed [131:0] prod;
    logic [32:0] t;
    adj_t r;
    for (int k = 0; k < 9; k++) begin
      j[k] = p.jac[k];
    end
    w = p.weight;
    cw = w * coef_shadow;
    r = '0;
    if (mode_shadow == wja_pkg::DIM_2D) begin
      cof[0] = j[4];
      cof[1] = -j[1];
      cof[3] = -j[3];
      cof[4] = j[0];
      foreach (cof[k]) begin
        if (k == 0 || k == 1 || k == 3 || k == 4) begin
          prod = cw * cof[k];
          t = round_clip(prod, 2 * FRAC);
          r.ent[k] = t[31:0];
          r.sat |= t[32];
        end
      end
    end else begin
      cof[0] = cofactor(j[4], j[8], j[5], j[7]);
      cof[1] = cofactor(j[7], j[2], j[1], j[8]);
      cof[2] = cofactor(j[1], j[5], j[4], j[2]);
      cof[3] = cofactor(j[6], j[5], j[3], j[8]);
      cof[4] = cofactor(j[0], j[8], j[2], j[6]);
      cof[5] = cofactor(j[3], j[2], j[0], j[5]);
      cof[6] = cofactor(j[3], j[7], j[6], j[4]);
      cof[7] = cofactor(j[6], j[1], j[0], j[7]);
      cof[8] = cofactor(j[0], j[4], j[1], j[3]);
      for (int k = 0; k < 9; k++) begin
        prod = cw * cof[k];
        t = round_clip(prod, 3 * FRAC);
        r.ent[k] = t[31:0];
        r.sat |= t[32];
      end
    end
    return r;
  endfunction

  function automatic wja_pkg::word_t rand_q();
    logic [31:0] raw;
    int unsigned bits;
    raw = $urandom;
    bits = $urandom_range(1, 19);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return MX;
          1: return MN;
          2: return '0;
          3: return ONE;
          default: return -ONE;
        endcase
      end
      1, 2: return raw;
      default: return $signed(raw << (32 - bits)) >>> (32 - bits);
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    for (int k = 0; k < 9; k++) begin
      p.jac[k] = rand_q();
    end
    p.weight = rand_q();
    return p;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  task automatic cfg_write(wja_pkg::cfg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_adj.size() != 0) @(negedge clk);
  endtask

  task automatic program_regs(wja_pkg::dim_t dim, wja_pkg::word_t coef);
    wait_idle();
    cfg_write(wja_pkg::REG_DIMENSION_MODE, {30'($urandom), dim});
    cfg_write(wja_pkg::REG_COEFFICIENT, coef);
    cfg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_point(point_t p, logic pin, adj_t want);
    while ($urandom_range(0, 99) < idle_in) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    beat <= p;
    pin_on <= pin;
    pin_want <= want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic run_phase(wja_pkg::dim_t dim, wja_pkg::word_t coef, int n);
    program_regs(dim, coef);
    repeat (n) send_point(rand_point(), 1'b0, '0);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= idle_out);
  end

  always @(posedge clk) begin : monitor
    adj_t got;
    adj_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        case (cfg_index)
          wja_pkg::REG_DIMENSION_MODE: mode_shadow = cfg_data[1:0];
          wja_pkg::REG_COEFFICIENT: coef_shadow = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        pending_adj.push_back(pin_on ? pin_want : weigh_adjugate(beat));
      end
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        got = '{'{out_r1c1, out_r1c2, out_r1c3, out_r2c1, out_r2c2, out_r2c3,
                  out_r3c1, out_r3c2, out_r3c3}, out_saturated};
        if (pending_adj.size() == 0) begin
          report_mismatch("unexpected beat r1c1", got.ent[0], '0);
        end else begin
          want = pending_adj.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (got.ent[k] !== want.ent[k]) begin
              report_mismatch($sformatf("r%0dc%0d", k / 3 + 1, k % 3 + 1),
                              got.ent[k], want.ent[k]);
            end
          end
          if (got.sat !== want.sat) begin
            report_mismatch("saturated", 32'(got.sat), 32'(want.sat));
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_in = 11;
    idle_out = 75;
    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].dim != mode_shadow || DIRECTED[i].coef != coef_shadow) begin
        program_regs(DIRECTED[i].dim, DIRECTED[i].coef);
      end
      send_point(DIRECTED[i].pt, DIRECTED[i].pin, DIRECTED[i].want);
    end
    run_phase(DIM_3D, rand_q(), 100);
    run_phase(wja_pkg::DIM_2D, rand_q(), 100);

    idle_in = 75;
    idle_out = 11;
    run_phase(DIM_ALT0, MX, 100);
    run_phase(DIM_ALT1, MN, 100);

    idle_in = 0;
    idle_out = 0;
    run_phase(wja_pkg::DIM_2D, '0, 100);
    run_phase(DIM_3D, ONE, 100);
    run_phase(wja_pkg::DIM_2D, rand_q(), 100);

    // drain, then give late or spurious beats a chance to show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
